>>> hdl/random_unused_entry_picker_macros.svh
// assertion macros shared by the picker rtl
`ifndef RANDOM_UNUSED_ENTRY_PICKER_MACROS_SVH
`define RANDOM_UNUSED_ENTRY_PICKER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define RUP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define RUP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rup_pkg.sv
// shared constants and codes for the random unused entry picker
`timescale 1ns / 1ps
`default_nettype none

package rup_pkg;

   // pool geometry
   localparam int POOLS     = 8;
   localparam int ENTRIES   = 256;
   localparam int WORD_BITS = 16;
   localparam int WORDS     = ENTRIES / WORD_BITS;
   localparam int ROWS      = POOLS * WORDS;

   // field and index widths
   localparam int POOL_W = $clog2(POOLS);
   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int BIT_W  = $clog2(WORD_BITS);
   localparam int WORD_W = $clog2(WORDS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int STAT_W = 2;
   localparam int MASK_W = 8;

   // csr port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_NO_DUP_MASK = '0;

   // command codes
   localparam logic CMD_DRAW = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_ERROR     = 2'd2;

endpackage

`default_nettype wire

>>> hdl/rup_req_if.sv
// request channel: command beats into the picker
`timescale 1ns / 1ps
`default_nettype none

interface rup_req_if;
   import rup_pkg::*;

   logic                valid;
   logic                ready;
   logic                command;
   logic [POOL_W-1:0]   pool_id;
   logic [IDX_W-1:0]    random_index;
   logic [CNT_W-1:0]    entry_count;

   modport source (output valid, command, pool_id, random_index, entry_count,
                   input ready);
   modport sink   (input valid, command, pool_id, random_index, entry_count,
                   output ready);
endinterface

`default_nettype wire

>>> hdl/rup_rsp_if.sv
// response channel: result beats out of the picker
`timescale 1ns / 1ps
`default_nettype none

interface rup_rsp_if;
   import rup_pkg::*;

   logic                valid;
   logic                ready;
   logic [IDX_W-1:0]    entry_index;
   logic [STAT_W-1:0]   status;

   modport source (output valid, entry_index, status, input ready);
   modport sink   (input valid, entry_index, status, output ready);
endinterface

`default_nettype wire

>>> hdl/random_unused_entry_picker.sv
// a load or a rejected draw registers its result at the accepting edge
// a draw reads one 16-bit word of used flags per cycle from the flag ram and shows its
// result on a hit or after the last word (start word, words to pool end, wrap to start)
// throughput: one item at a time; a new item is taken when idle and the output register is free
// reset: counts, mask and per-row valid bits clear at once, no ram clearing pass needed
`timescale 1ns / 1ps
`default_nettype none
`include "random_unused_entry_picker_macros.svh"

module random_unused_entry_picker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   rup_req_if.sink                              req_port,
   rup_rsp_if.source                            rsp_port,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [rup_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [rup_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [rup_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import rup_pkg::*;

   typedef enum logic {S_IDLE, S_SCAN} state_type;

   localparam logic PH_A = 1'b0;   // from the start word up to the pool end
   localparam logic PH_B = 1'b1;   // wrapped, from word zero back to the start word

   // registers
   state_type          state_ff, state_in;
   logic [POOL_W-1:0]  pool_ff, pool_in;
   logic [IDX_W-1:0]   start_ff, start_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               nodup_ff, nodup_in;
   logic               first_ff, first_in;
   logic [WORD_W-1:0]  iss_word_ff, iss_word_in;
   logic               iss_phase_ff, iss_phase_in;
   logic [WORD_W-1:0]  chk_word_ff, chk_word_in;
   logic               chk_phase_ff, chk_phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [CNT_W-1:0]   counts_ff [POOLS];
   logic [CNT_W-1:0]   counts_in [POOLS];
   logic [ROWS-1:0]    row_valid_ff, row_valid_in;

   // datapath signals
   logic                 req_accept;
   logic                 csr_write;
   logic [CNT_W-1:0]     req_count;
   logic [CNT_W-1:0]     req_count_m1;
   logic [CNT_W-1:0]     count_m1;
   logic [WORD_W-1:0]    last_word;
   logic [ROW_W-1:0]     chk_row;
   logic [WORD_BITS-1:0] ram_rdata;
   logic [WORD_BITS-1:0] scan_word;
   logic [WORD_BITS-1:0] scan_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic                 start_free;
   logic                 hit;
   logic [BIT_W-1:0]     hit_bit;
   logic [IDX_W-1:0]     hit_index;
   logic                 last_visit;
   logic                 ram_we;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [ROW_W-1:0]     ram_raddr;
   logic [WORD_W:0]      first_next;
   logic [WORD_W:0]      iss_next;

   // lowest set bit of a flag word
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (v[b]) begin
            r = BIT_W'(b);
         end
      end
      return r;
   endfunction

   // word visit order: start word to last word, then zero back to the start word
   function automatic logic [WORD_W:0] next_visit(input logic [WORD_W-1:0] word,
                                                  input logic phase,
                                                  input logic [WORD_W-1:0] last);
      logic [WORD_W:0] r;
      if (phase == PH_A && word == last) begin
         r = {PH_B, {WORD_W{1'b0}}};
      end else begin
         r = {phase, word + WORD_W'(1)};
      end
      return r;
   endfunction

   // handshakes
   assign req_accept = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_port.ready);
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.entry_index = rsp_index_ff;
   assign rsp_port.status      = rsp_status_ff;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[CSR_ADDR_W-1:2] == CSR_NO_DUP_MASK);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == CSR_NO_DUP_MASK)
                       ? CSR_DATA_W'(mask_ff) : '0;
   assign mask_in = csr_write ? csr_pwdata[MASK_W-1:0] : mask_ff;

   // accept-time view of the addressed pool
   assign req_count    = counts_ff[req_port.pool_id];
   assign req_count_m1 = req_count - CNT_W'(1);
   assign first_next   = next_visit(req_port.random_index[IDX_W-1:BIT_W], PH_A,
                                    req_count_m1[IDX_W-1:BIT_W]);

   // scan-time view
   assign count_m1  = count_ff - CNT_W'(1);
   assign last_word = count_m1[IDX_W-1:BIT_W];
   assign iss_next  = next_visit(iss_word_ff, iss_phase_ff, last_word);
   assign chk_row   = {pool_ff, chk_word_ff};
   assign ram_raddr = (state_ff == S_IDLE)
                      ? {req_port.pool_id, req_port.random_index[IDX_W-1:BIT_W]}
                      : {pool_ff, iss_word_ff};

   // used flag ram, one word per row
   rup_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (ROWS)
   ) u_flags (
      .clock (clock),
      .we    (ram_we),
      .waddr (chk_row),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // check the word that came back: start entry first, then the candidate window
   always_comb begin
      logic [IDX_W-1:0] idx;
      idx       = '0;
      scan_word = ram_rdata & {WORD_BITS{row_valid_ff[chk_row]}};
      for (int b = 0; b < WORD_BITS; b++) begin
         idx = {chk_word_ff, BIT_W'(b)};
         if (chk_phase_ff == PH_A) begin
            scan_mask[b] = (idx > start_ff) && ({1'b0, idx} < count_ff);
         end else begin
            scan_mask[b] = idx < start_ff;
         end
      end
      free_bits  = ~scan_word & scan_mask;
      start_free = !nodup_ff || !scan_word[start_ff[BIT_W-1:0]];
      if (first_ff && start_free) begin
         hit     = 1'b1;
         hit_bit = start_ff[BIT_W-1:0];
      end else begin
         hit     = |free_bits;
         hit_bit = lowest_set(free_bits);
      end
      hit_index  = {chk_word_ff, hit_bit};
      last_visit = (chk_phase_ff == PH_B) && (chk_word_ff == start_ff[IDX_W-1:BIT_W]);
      ram_wdata  = scan_word | (WORD_BITS'(1) << hit_bit);
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      pool_in       = pool_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      nodup_in      = nodup_ff;
      first_in      = first_ff;
      iss_word_in   = iss_word_ff;
      iss_phase_in  = iss_phase_ff;
      chk_word_in   = chk_word_ff;
      chk_phase_in  = chk_phase_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      counts_in     = counts_ff;
      row_valid_in  = row_valid_ff;
      ram_we        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // every pool id fits below the pool count, so no range check here
            if (req_accept) begin
               if (req_port.command == CMD_LOAD) begin
                  if (req_port.entry_count > CNT_W'(ENTRIES)) begin
                     counts_in[req_port.pool_id] = CNT_W'(ENTRIES);
                  end else begin
                     counts_in[req_port.pool_id] = req_port.entry_count;
                  end
                  for (int w = 0; w < WORDS; w++) begin
                     row_valid_in[{req_port.pool_id, WORD_W'(w)}] = 1'b0;
                  end
                  rsp_valid_in  = 1'b1;
                  rsp_index_in  = '0;
                  rsp_status_in = ST_OK;
               end else if ({1'b0, req_port.random_index} >= req_count) begin
                  rsp_valid_in  = 1'b1;
                  rsp_index_in  = '0;
                  rsp_status_in = ST_ERROR;
               end else begin
                  state_in     = S_SCAN;
                  pool_in      = req_port.pool_id;
                  start_in     = req_port.random_index;
                  count_in     = req_count;
                  nodup_in     = mask_ff[req_port.pool_id];
                  first_in     = 1'b1;
                  chk_word_in  = req_port.random_index[IDX_W-1:BIT_W];
                  chk_phase_in = PH_A;
                  iss_word_in  = first_next[WORD_W-1:0];
                  iss_phase_in = first_next[WORD_W];
               end
            end
         end
         S_SCAN: begin
            // one word read issued and one word checked every cycle
            first_in     = 1'b0;
            chk_word_in  = iss_word_ff;
            chk_phase_in = iss_phase_ff;
            iss_word_in  = iss_next[WORD_W-1:0];
            iss_phase_in = iss_next[WORD_W];
            if (hit) begin
               ram_we                = 1'b1;
               row_valid_in[chk_row] = 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_index_in          = hit_index;
               rsp_status_in         = ST_OK;
               state_in              = S_IDLE;
            end else if (last_visit) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = '0;
               rsp_status_in = ST_EXHAUSTED;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
         mask_ff      <= '0;
         counts_ff    <= '{default: '0};
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         mask_ff      <= mask_in;
         counts_ff    <= counts_in;
         row_valid_ff <= row_valid_in;
      end
      pool_ff       <= pool_in;
      start_ff      <= start_in;
      count_ff      <= count_in;
      nodup_ff      <= nodup_in;
      iss_word_ff   <= iss_word_in;
      iss_phase_ff  <= iss_phase_in;
      chk_word_ff   <= chk_word_in;
      chk_phase_ff  <= chk_phase_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   // checks
   `RUP_ASSERT_NOW(a_mark_one_flag, ram_we && nodup_ff,
      $countones(ram_wdata) == $countones(scan_word) + 1,
      "flag write does not set exactly one new used flag")
   `RUP_ASSERT_NOW(a_hit_in_pool, ram_we, {1'b0, hit_index} < count_ff,
      "handed out entry lies beyond the pool count")
   `RUP_ASSERT_NEXT(a_exhausted, (state_ff == S_SCAN) && !hit && last_visit,
      rsp_valid_ff && (rsp_status_ff == ST_EXHAUSTED),
      "finished scan without a free entry did not report exhausted")
   `RUP_ASSERT_NEXT(a_bad_draw,
      req_accept && (req_port.command == CMD_DRAW)
         && ({1'b0, req_port.random_index} >= req_count),
      rsp_valid_ff && (rsp_status_ff == ST_ERROR) && (state_ff == S_IDLE),
      "out of range draw not rejected")
endmodule

`default_nettype wire

>>> hdl/rup_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module rup_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

`default_nettype wire
